/* hdl/bsst_pkg.sv */
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared types and constants for the bounded set span tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bsst_pkg;

   // Store geometry
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // Field widths
   localparam int VAL_W = 32;
   localparam int CAP_W = 11;
   localparam int HC_W  = 11;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
   localparam logic [VAL_W-1:0] SIGN_BIAS = 32'h8000_0000;
   localparam logic [VAL_W-1:0] GAP_RESET = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } bsst_state_type;

   typedef struct packed {
      logic load;     // latch the beat and decide whether it fits
      logic rd_en;    // read the next stored entry
      logic commit;   // store, update extremes, present the result
   } bsst_cmd_type;

   typedef struct packed {
      logic scan_needed;  // fits and at least one entry is held
      logic scan_last;    // current read is the last held entry
      logic pipe_busy;    // distance pipeline still holds data
      logic out_busy;     // result register full and stalled
   } bsst_sts_type;

   // Biased key: unsigned order of keys follows signed order of values
   function automatic logic [VAL_W-1:0] to_key(input logic [VAL_W-1:0] v);
      return v ^ SIGN_BIAS;
   endfunction

endpackage : bsst_pkg

`default_nettype wire

/* hdl/bounded_set_span_tracker_top.sv */
// ----------------------------------------------------------------------------
// bounded_set_span_tracker_top
// Bounded set of signed numbers reporting shortest and longest pairwise span.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one signed 32-bit value per beat (valid/stall).
//   rsp_ channel returns one result beat per request: accepted flag, count
//   held, and the shortest and longest spans once two or more are held.
//   csr_wr_en/csr_wr_data set the capacity (reset 1024, saturates at the
//   store depth); write it only while the block is idle.
// Sequence:
//   An accepted value is compared with every held entry, one store read
//   per cycle through a single-port memory, followed by a distance pipeline
//   (read data register, then distance register) and a commit. The next beat
//   is taken once the commit is done; a rejected or first item skips the scan
//   and goes straight to commit. A full store always rejects.
// Reset and stall:
//   Reset empties the set and clears the pending result. The result sits in
//   an output register; the next request is taken meanwhile, and its commit
//   waits while rsp_stall holds the previous result.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_span_tracker_top
   import bsst_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic [VAL_W-1:0] req_value,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic             rsp_accepted,
   output      logic [HC_W-1:0]  rsp_held_count,
   output      logic             rsp_spans_valid,
   output      logic [VAL_W-1:0] rsp_shortest_span,
   output      logic [VAL_W-1:0] rsp_longest_span
);

   bsst_cmd_type cmd;
   bsst_sts_type sts;

   bsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bsst_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_value         (req_value),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_held_count    (rsp_held_count),
      .rsp_spans_valid   (rsp_spans_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span)
   );

endmodule : bounded_set_span_tracker_top

`default_nettype wire

/* hdl/bsst_ctrl.sv */
// ----------------------------------------------------------------------------
// bsst_ctrl
// Sequencer: accepts a beat, steps the scan over held entries when needed, then commits.
// ----------------------------------------------------------------------------
`default_nettype none

module bsst_ctrl
   import bsst_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire bsst_sts_type sts,
   output      bsst_cmd_type cmd
);

   bsst_state_type state_ff, state_in;
   logic           req_take;

   assign req_take = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = sts.scan_needed ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_take;
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_COMMIT: begin
            // hold until the previous result has left
            cmd.commit = !sts.out_busy;
         end
         default: cmd = '0;
      endcase
   end

endmodule : bsst_ctrl

`default_nettype wire

/* hdl/bsst_dp.sv */
// ----------------------------------------------------------------------------
// bsst_dp
// Datapath: value store, distance pipeline, running extremes, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsst_dp
   import bsst_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data,
   input  wire logic [VAL_W-1:0] req_value,
   input  wire bsst_cmd_type     cmd,
   output      bsst_sts_type     sts,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic             rsp_accepted,
   output      logic [HC_W-1:0]  rsp_held_count,
   output      logic             rsp_spans_valid,
   output      logic [VAL_W-1:0] rsp_shortest_span,
   output      logic [VAL_W-1:0] rsp_longest_span
);

   logic [VAL_W-1:0] mem [STORE_DEPTH];

   logic [CAP_W-1:0]  cap_ff;
   logic [VAL_W-1:0]  value_ff;
   logic              take_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [VAL_W-1:0]  rd_data_ff;
   logic              rd_vld_ff;
   logic [VAL_W-1:0]  dist_ff, dist_in;
   logic              dist_vld_ff;
   logic [VAL_W-1:0]  gap_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [VAL_W-1:0]  least_ff, greatest_ff;
   logic              rsp_valid_ff;
   logic              out_acc_ff;
   logic [VAL_W-1:0]  out_gap_ff;

   logic [CMP_W-1:0]  cap_ext, limit, count_ext;
   logic              fits;
   logic [VAL_W-1:0]  key_v, key_rd, key_lo, key_hi;
   logic              spans_ok;

   // effective capacity saturates at the store depth
   assign cap_ext   = CMP_W'(cap_ff);
   assign limit     = (cap_ext > CMP_W'(STORE_DEPTH)) ? CMP_W'(STORE_DEPTH) : cap_ext;
   assign count_ext = CMP_W'(count_ff);
   assign fits      = count_ext < limit;

   assign key_v  = to_key(value_ff);
   assign key_rd = to_key(rd_data_ff);
   assign key_lo = to_key(least_ff);
   assign key_hi = to_key(greatest_ff);
   assign dist_in = (key_v >= key_rd) ? (key_v - key_rd) : (key_rd - key_v);

   assign sts.scan_needed = fits && (count_ff != '0);
   assign sts.scan_last   = CNT_W'(idx_ff) == (count_ff - 1'b1);
   assign sts.pipe_busy   = rd_vld_ff || dist_vld_ff;
   assign sts.out_busy    = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end
      if (dist_vld_ff == 1'b0 || rd_vld_ff) begin
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && take_ff) begin
         mem[count_ff[ADDR_W-1:0]] <= value_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff     <= 1'b0;
         idx_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         dist_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.rd_en;
         dist_vld_ff <= rd_vld_ff;
         if (cmd.load) begin
            take_ff <= fits;
            idx_ff  <= '0;
         end else if (cmd.rd_en) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff      <= GAP_RESET;
         count_ff    <= '0;
         least_ff    <= '0;
         greatest_ff <= '0;
      end else begin
         if (dist_vld_ff && (dist_ff < gap_ff)) begin
            gap_ff <= dist_ff;
         end
         if (cmd.commit && take_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == '0) begin
               least_ff    <= value_ff;
               greatest_ff <= value_ff;
            end else begin
               if (key_v < key_lo) begin
                  least_ff <= value_ff;
               end
               if (key_v > key_hi) begin
                  greatest_ff <= value_ff;
               end
            end
         end
      end
   end

   // result register; extremes and count change only at commit, so they
   // stay put while the result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_acc_ff <= take_ff;
         out_gap_ff <= gap_ff;
      end
   end

   assign spans_ok          = count_ff >= CNT_W'(2);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = out_acc_ff;
   assign rsp_held_count    = HC_W'(count_ff);
   assign rsp_spans_valid   = spans_ok;
   assign rsp_shortest_span = spans_ok ? out_gap_ff : '0;
   assign rsp_longest_span  = spans_ok ? (key_hi - key_lo) : '0;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("entry count above store depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("entry count moved by other than one");

   a_extremes_order: assert property (@(posedge clock) disable iff (reset)
      key_lo <= key_hi)
      else $error("least value above greatest value");

   a_gap_in_span: assert property (@(posedge clock) disable iff (reset)
      spans_ok && !sts.pipe_busy |-> gap_ff <= (key_hi - key_lo))
      else $error("shortest span exceeds longest span");
`endif

endmodule : bsst_dp

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded set span tracker.
// ----------------------------------------------------------------------------
// A short table of capacity writes and values covers the empty, full,
// saturated and lowered-capacity cases; rows with obvious answers carry
// their report, the rest are predicted. A random part then walks the set
// through a dozen capacity settings. Every result beat is compared field by
// field with the oldest predicted report. Both channels idle in random
// bursts except in the final phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import bsst_pkg::*;

   localparam int WATCHDOG_LIMIT = 8000;
   localparam int RANDOM_PHASES  = 12;

   typedef struct packed {
      logic             accepted;
      logic [HC_W-1:0]  held_count;
      logic             spans_valid;
      logic [VAL_W-1:0] shortest_span;
      logic [VAL_W-1:0] longest_span;
   } span_report_type;

   typedef enum logic {ROW_CAPACITY, ROW_VALUE} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [VAL_W-1:0] data;
      logic             typed;
      span_report_type  report;
   } drill_row_type;

   localparam drill_row_type DRILL_TABLE [24] = '{
      '{ROW_CAPACITY, 32'd0,         1'b0, '0},
      '{ROW_VALUE,    32'h0000_0000, 1'b1, '{1'b0, 11'd0, 1'b0, 32'h0, 32'h0}},
      '{ROW_VALUE,    32'hFFFF_FFFF, 1'b1, '{1'b0, 11'd0, 1'b0, 32'h0, 32'h0}},
      '{ROW_CAPACITY, 32'd1,         1'b0, '0},
      '{ROW_VALUE,    32'h8000_0000, 1'b1, '{1'b1, 11'd1, 1'b0, 32'h0, 32'h0}},
      '{ROW_VALUE,    32'h7FFF_FFFF, 1'b1, '{1'b0, 11'd1, 1'b0, 32'h0, 32'h0}},
      '{ROW_CAPACITY, 32'd2,         1'b0, '0},
      '{ROW_VALUE,    32'h7FFF_FFFF, 1'b1,
        '{1'b1, 11'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
      '{ROW_VALUE,    32'h0000_0000, 1'b1,
        '{1'b0, 11'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
      // above the store depth: saturates
      '{ROW_CAPACITY, 32'd2047,      1'b0, '0},
      '{ROW_VALUE,    32'h0000_0000, 1'b0, '0},
      '{ROW_VALUE,    32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_VALUE,    32'h0000_0000, 1'b0, '0},
      '{ROW_VALUE,    32'h5555_5555, 1'b0, '0},
      '{ROW_VALUE,    32'hAAAA_AAAA, 1'b0, '0},
      '{ROW_CAPACITY, 32'd1024,      1'b0, '0},
      '{ROW_VALUE,    32'h0000_0001, 1'b0, '0},
      '{ROW_VALUE,    32'h8000_0001, 1'b0, '0},
      '{ROW_VALUE,    32'h7FFF_FFFE, 1'b0, '0},
      // lowered below the count: everything bounces, set is kept
      '{ROW_CAPACITY, 32'd4,         1'b0, '0},
      '{ROW_VALUE,    32'h1234_5678, 1'b1,
        '{1'b0, 11'd10, 1'b1, 32'h0, 32'hFFFF_FFFF}},
      '{ROW_CAPACITY, 32'd9,         1'b0, '0},
      '{ROW_VALUE,    32'h0F0F_0F0F, 1'b1,
        '{1'b0, 11'd10, 1'b1, 32'h0, 32'hFFFF_FFFF}},
      '{ROW_VALUE,    32'hEDCB_A987, 1'b1,
        '{1'b0, 11'd10, 1'b1, 32'h0, 32'hFFFF_FFFF}}
   };

   logic             clock             = 1'b0;
   logic             reset             = 1'b1;
   logic             csr_wr_en         = 1'b0;
   logic [CAP_W-1:0] csr_wr_data       = '0;
   logic             req_valid         = 1'b0;
   logic             req_stall;
   logic [VAL_W-1:0] req_value         = '0;
   logic             rsp_valid;
   logic             rsp_stall         = 1'b0;
   logic             rsp_accepted;
   logic [HC_W-1:0]  rsp_held_count;
   logic             rsp_spans_valid;
   logic [VAL_W-1:0] rsp_shortest_span;
   logic [VAL_W-1:0] rsp_longest_span;

   // mirror of the set
   logic [VAL_W-1:0] held_values [$];
   logic [VAL_W-1:0] gap_floor   = '1;
   logic [VAL_W-1:0] low_key     = '0;
   logic [VAL_W-1:0] high_key    = '0;
   logic [CAP_W-1:0] cap_setting = CAP_RESET;

   span_report_type pending_reports [$];
   int              fail_count = 0;
   int              stuck_cycles = 0;
   bit              quiet = 1'b0;
   bit              stall_on = 1'b0;
   int              burst_left = 0;

   bounded_set_span_tracker_top DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_held_count    (rsp_held_count),
      .rsp_spans_valid   (rsp_spans_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span)
   );

   always #4 clock = ~clock;

   // Add one value to the mirror and return the report it should produce.
   function automatic span_report_type predict_span(input logic [VAL_W-1:0] v);
      span_report_type  r;
      int               room;
      logic [VAL_W-1:0] k;
      logic [VAL_W-1:0] sk;
      logic [VAL_W-1:0] d;
      room = (int'(cap_setting) > STORE_DEPTH) ? STORE_DEPTH : int'(cap_setting);
      k = v ^ SIGN_BIAS;
      r = '0;
      if (held_values.size() < room) begin
         foreach (held_values[i]) begin
            sk = held_values[i] ^ SIGN_BIAS;
            d  = (k >= sk) ? k - sk : sk - k;
            if (d < gap_floor)
               gap_floor = d;
         end
         if (held_values.size() == 0) begin
            low_key  = k;
            high_key = k;
         end else begin
            if (k < low_key)
               low_key = k;
            if (k > high_key)
               high_key = k;
         end
         held_values = {held_values, v};
         r.accepted = 1'b1;
      end
      r.held_count = HC_W'(held_values.size());
      if (held_values.size() >= 2) begin
         r.spans_valid   = 1'b1;
         r.shortest_span = gap_floor;
         r.longest_span  = high_key - low_key;
      end
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] base;
      case ($urandom_range(0, 9)) inside
         [0:3]: return $urandom;
         [4:6]: begin
            // land close to something already held
            if (held_values.size() > 0)
               base = held_values[$urandom_range(0, held_values.size() - 1)];
            else
               base = $urandom;
            return base + VAL_W'($urandom_range(0, 2000)) - 32'd1000;
         end
         7: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h8000_0001;
               2: return 32'h7FFF_FFFF;
               3: return 32'h7FFF_FFFE;
               4: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return VAL_W'($urandom_range(0, 4000)) - 32'd2000;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic offer_value(input logic [VAL_W-1:0] v, input logic typed,
                              input span_report_type report);
      span_report_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = v;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = predict_span(v);
      pending_reports = {pending_reports, (typed ? report : predicted)};
      @(negedge clock);
   endtask

   task automatic drain_reports();
      req_valid = 1'b0;
      while (pending_reports.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] c);
      drain_reports();
      csr_wr_en   = 1'b1;
      csr_wr_data = c;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      cap_setting = c;
   endtask

   task automatic report_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Result side: bursts of stall between free-running stretches.
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall = 1'b0;
      end else begin
         if (burst_left == 0) begin
            stall_on   = ($urandom_range(0, 2) == 0);
            burst_left = stall_on ? $urandom_range(1, 8) : $urandom_range(1, 40);
         end
         burst_left--;
         rsp_stall = stall_on;
      end
   end

   always @(posedge clock) begin
      span_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual count %0d",
                     $time, rsp_held_count);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            report_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            report_field("held_count", 32'(want.held_count), 32'(rsp_held_count));
            report_field("spans_valid", 32'(want.spans_valid), 32'(rsp_spans_valid));
            report_field("shortest_span", want.shortest_span, rsp_shortest_span);
            report_field("longest_span", want.longest_span, rsp_longest_span);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      int          n_items;
      logic [CAP_W-1:0] cap;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DRILL_TABLE[r]) begin
         if (DRILL_TABLE[r].kind == ROW_CAPACITY)
            write_capacity(DRILL_TABLE[r].data[CAP_W-1:0]);
         else
            offer_value(DRILL_TABLE[r].data, DRILL_TABLE[r].typed, DRILL_TABLE[r].report);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // mostly leave room to grow; now and then full, lowered or saturated
         case ($urandom_range(0, 9))
            0: cap = CAP_W'(held_values.size() / 2);
            1: cap = CAP_W'(held_values.size());
            2: cap = CAP_W'(2047);
            3: cap = CAP_RESET;
            default: cap = CAP_W'(held_values.size() + $urandom_range(8, 60));
         endcase
         if (phase == RANDOM_PHASES - 1) begin
            cap   = CAP_W'(2047);
            quiet = 1'b1;
         end
         write_capacity(cap);
         n_items = (phase == RANDOM_PHASES - 1) ? 40 : 49;
         for (int n = 0; n < n_items; n++) begin
            // hold the sender until the result side catches up
            if ((phase == 3 && n == 20) || $urandom_range(0, 40) == 0)
               drain_reports();
            offer_value(pick_value(), 1'b0, '0);
         end
      end

      drain_reports();
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
